// ===== rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants for the segment midpoint pipeline
// Fixed-point widths, case codes, sideband words and the clamp helper.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int NUM_W     = DOT_W + 1;
    localparam int THR_W     = 16;
    localparam int CASE_W    = 3;
    localparam int SPLIT_W   = 18;
    localparam int PLO_W     = DOT_W + SPLIT_W + 1;
    localparam int PHI_W     = 2 * DOT_W - SPLIT_W;
    localparam int WIDE_W    = 2 * DOT_W;
    localparam int DIV_W     = WIDE_W + 2;
    localparam int Q_W       = 16;
    localparam int S_W       = Q_W + 1;
    localparam int BS_W      = DOT_W + S_W + 1;
    localparam int TN_W      = BS_W + 1;
    localparam int DS_W      = DIFF_W + S_W + 1;
    localparam int SUM_W     = DS_W + 1;
    localparam int MID_SHIFT = Q_W + 1;
    localparam int PIPE_LAT  = 2 * Q_W + 13;
    localparam int S8_IDX    = Q_W + 7;

    localparam logic [S_W-1:0]   S_ONE     = {1'b1, {Q_W{1'b0}}};
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef enum logic [CASE_W-1:0] {
        CASE_BOTH     = 3'd0,
        CASE_FIRST    = 3'd1,
        CASE_SECOND   = 3'd2,
        CASE_PARALLEL = 3'd3,
        CASE_GENERAL  = 3'd4
    } t_case;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic [2:0][DIFF_W-1:0]  d1;
        logic [2:0][DIFF_W-1:0]  d2;
    } t_geom;

    typedef struct packed {
        t_geom            g;
        logic             deg_a;
        logic             deg_e;
        logic             par;
        logic             sg_zero;
        logic             sg_one;
        logic             fe_zero;
        logic             fe_one;
        logic             ca_zero;
        logic             ca_one;
        logic             bca_zero;
        logic             bca_one;
        logic [DOT_W-1:0] b;
        logic [DOT_W-1:0] f;
        logic [DOT_W-1:0] e;
    } t_side1;

    typedef struct packed {
        t_geom          g;
        t_case          code;
        logic           tneg;
        logic           tover;
        logic           teq;
        logic [S_W-1:0] s_gen;
        logic [S_W-1:0] s_ca;
        logic [S_W-1:0] s_bca;
        logic [S_W-1:0] t_fe;
    } t_side2;

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        return DIFF_W'(x) - DIFF_W'(y);
    endfunction

    function automatic logic [S_W-1:0] clamp_q(
        input logic           zero,
        input logic           one,
        input logic [Q_W-1:0] q
    );
        logic [S_W-1:0] res;
        res = {1'b0, q};
        if (one) begin
            res = S_ONE;
        end
        if (zero) begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// ===== rtl/segment_closest_midpoint.sv =====
// ----------------------------------------------------------------------------
// segment_closest_midpoint: midpoint of the closest points of two segments
// Pipelined clamped segment-segment solver in fixed point.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle unless stalled and returns one word per
// pair, in order of acceptance. The core is two 16-stage restoring
// dividers in series: the first resolves s (and the clamped fallback
// quotients in parallel units), the second resolves t from s. The whole pipe
// advances together and freezes only while a result waits under stall.
// The threshold register may be written only while the pipe is empty.
// ----------------------------------------------------------------------------
module segment_closest_midpoint (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scm_pkg::THR_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_start_x,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_start_y,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_start_z,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_end_x,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_end_y,
    input  logic signed [scm_pkg::COORD_W-1:0] i_first_end_z,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_start_x,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_start_y,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_start_z,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_end_x,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_end_y,
    input  logic signed [scm_pkg::COORD_W-1:0] i_second_end_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [scm_pkg::COORD_W-1:0] o_mid_x,
    output logic signed [scm_pkg::COORD_W-1:0] o_mid_y,
    output logic signed [scm_pkg::COORD_W-1:0] o_mid_z,
    output logic [scm_pkg::CASE_W-1:0]         o_case_code
);
    import scm_pkg::*;

    logic en;
    logic [THR_W-1:0] r_thr;
    logic [PIPE_LAT-1:0] r_vld;

    logic signed [COORD_W-1:0] in_p1 [3];
    logic signed [COORD_W-1:0] in_q1 [3];
    logic signed [COORD_W-1:0] in_p2 [3];
    logic signed [COORD_W-1:0] in_q2 [3];

    // stage 1
    t_geom r_g1;
    logic signed [DIFF_W-1:0] r_r1 [3];
    // stage 2
    t_geom r_g2;
    logic signed [PROD_W-1:0] r_pa [3];
    logic signed [PROD_W-1:0] r_pe [3];
    logic signed [PROD_W-1:0] r_pb [3];
    logic signed [PROD_W-1:0] r_pc [3];
    logic signed [PROD_W-1:0] r_pf [3];
    // stage 3
    t_geom r_g3;
    logic signed [DOT_W-1:0] r_a3, r_e3, r_b3, r_c3, r_f3;
    // stage 4
    t_geom r_g4;
    logic signed [DOT_W-1:0] r_a4, r_e4, r_b4, r_c4, r_f4;
    logic r_deg_a4, r_deg_e4;
    logic signed [DOT_W-1:0] mx [4];
    logic signed [DOT_W-1:0] my [4];
    logic signed [PLO_W-1:0] r_plo [4];
    logic signed [PHI_W-1:0] r_phi [4];
    // stage 5
    t_geom r_g5;
    logic signed [DOT_W-1:0] r_a5, r_e5, r_b5, r_c5, r_f5;
    logic r_deg_a5, r_deg_e5;
    logic signed [WIDE_W-1:0] r_wp [4];
    // stage 6
    t_geom r_g6;
    logic signed [DOT_W-1:0] r_a6, r_e6, r_b6, r_f6;
    logic r_deg_a6, r_deg_e6;
    logic signed [WIDE_W-1:0] r_den6, r_sn6;
    logic signed [NUM_W-1:0] r_nc6, r_bc6;
    // first divider segment
    t_side1 r_sb1 [Q_W+1];
    logic [DIV_W-1:0] r_dn [4];
    logic [DIV_W-1:0] r_dd [4];
    logic [Q_W-1:0] q1 [4];
    // stage 8
    t_side1 sb1_out;
    logic [S_W-1:0] s_gen;
    t_case code8;
    t_geom r_g8;
    t_case r_code8;
    logic [S_W-1:0] r_s8, r_tfe8, r_sca8, r_sbca8;
    logic signed [BS_W-1:0] r_bs8;
    logic signed [DOT_W-1:0] r_f8, r_e8;
    // stage 9
    t_geom r_g9;
    t_case r_code9;
    logic [S_W-1:0] r_s9, r_tfe9, r_sca9, r_sbca9;
    logic signed [TN_W-1:0] r_tn9, r_lim9;
    // second divider segment
    t_side2 r_sb2 [Q_W+1];
    logic [DIV_W-1:0] r_tnum, r_tden;
    logic [Q_W-1:0] qt;
    // stage 11
    t_side2 sb2_out;
    logic [S_W-1:0] fin_s, fin_t;
    t_geom r_g11;
    t_case r_code11;
    logic [S_W-1:0] r_s11, r_t11;
    // stage 12
    t_geom r_g12;
    t_case r_code12;
    logic signed [DS_W-1:0] r_ds [3];
    logic signed [DS_W-1:0] r_dt [3];
    // output
    logic signed [SUM_W-1:0] sum_v [3];
    logic signed [COORD_W-1:0] r_mid [3];
    t_case r_code;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    assign in_p1[0] = i_first_start_x;
    assign in_p1[1] = i_first_start_y;
    assign in_p1[2] = i_first_start_z;
    assign in_q1[0] = i_first_end_x;
    assign in_q1[1] = i_first_end_y;
    assign in_q1[2] = i_first_end_z;
    assign in_p2[0] = i_second_start_x;
    assign in_p2[1] = i_second_start_y;
    assign in_p2[2] = i_second_start_z;
    assign in_q2[0] = i_second_end_x;
    assign in_q2[1] = i_second_end_y;
    assign in_q2[2] = i_second_end_z;

    // direction vectors and offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_g1.p1[i] <= in_p1[i];
                r_g1.p2[i] <= in_p2[i];
                r_g1.d1[i] <= diff(in_q1[i], in_p1[i]);
                r_g1.d2[i] <= diff(in_q2[i], in_p2[i]);
                r_r1[i]    <= diff(in_p1[i], in_p2[i]);
            end
        end
    end

    // dot product terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g2 <= r_g1;
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= $signed(r_g1.d1[i]) * $signed(r_g1.d1[i]);
                r_pe[i] <= $signed(r_g1.d2[i]) * $signed(r_g1.d2[i]);
                r_pb[i] <= $signed(r_g1.d1[i]) * $signed(r_g1.d2[i]);
                r_pc[i] <= $signed(r_g1.d1[i]) * r_r1[i];
                r_pf[i] <= $signed(r_g1.d2[i]) * r_r1[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g3 <= r_g2;
            r_a3 <= DOT_W'(r_pa[0]) + DOT_W'(r_pa[1]) + DOT_W'(r_pa[2]);
            r_e3 <= DOT_W'(r_pe[0]) + DOT_W'(r_pe[1]) + DOT_W'(r_pe[2]);
            r_b3 <= DOT_W'(r_pb[0]) + DOT_W'(r_pb[1]) + DOT_W'(r_pb[2]);
            r_c3 <= DOT_W'(r_pc[0]) + DOT_W'(r_pc[1]) + DOT_W'(r_pc[2]);
            r_f3 <= DOT_W'(r_pf[0]) + DOT_W'(r_pf[1]) + DOT_W'(r_pf[2]);
        end
    end

    // wide products a*e, b*b, b*f, c*e as two partial products each
    assign mx[0] = r_a3;
    assign my[0] = r_e3;
    assign mx[1] = r_b3;
    assign my[1] = r_b3;
    assign mx[2] = r_b3;
    assign my[2] = r_f3;
    assign mx[3] = r_c3;
    assign my[3] = r_e3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g4     <= r_g3;
            r_a4     <= r_a3;
            r_e4     <= r_e3;
            r_b4     <= r_b3;
            r_c4     <= r_c3;
            r_f4     <= r_f3;
            r_deg_a4 <= r_a3 <= $signed({{(DOT_W-THR_W){1'b0}}, r_thr});
            r_deg_e4 <= r_e3 <= $signed({{(DOT_W-THR_W){1'b0}}, r_thr});
            for (int j = 0; j < 4; j++) begin
                r_plo[j] <= mx[j] * $signed({1'b0, my[j][SPLIT_W-1:0]});
                r_phi[j] <= mx[j] * $signed(my[j][DOT_W-1:SPLIT_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g5     <= r_g4;
            r_a5     <= r_a4;
            r_e5     <= r_e4;
            r_b5     <= r_b4;
            r_c5     <= r_c4;
            r_f5     <= r_f4;
            r_deg_a5 <= r_deg_a4;
            r_deg_e5 <= r_deg_e4;
            for (int j = 0; j < 4; j++) begin
                r_wp[j] <= WIDE_W'(r_plo[j]) + (WIDE_W'(r_phi[j]) <<< SPLIT_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g6     <= r_g5;
            r_a6     <= r_a5;
            r_e6     <= r_e5;
            r_b6     <= r_b5;
            r_f6     <= r_f5;
            r_deg_a6 <= r_deg_a5;
            r_deg_e6 <= r_deg_e5;
            r_den6   <= r_wp[0] - r_wp[1];
            r_sn6    <= r_wp[2] - r_wp[3];
            r_nc6    <= -NUM_W'(r_c5);
            r_bc6    <= NUM_W'(r_b5) - NUM_W'(r_c5);
        end
    end

    // clamp decisions and divider operands
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0].g        <= r_g6;
            r_sb1[0].deg_a    <= r_deg_a6;
            r_sb1[0].deg_e    <= r_deg_e6;
            r_sb1[0].par      <= (r_den6 == 0);
            r_sb1[0].sg_zero  <= (r_sn6 <= 0);
            r_sb1[0].sg_one   <= (r_sn6 >= r_den6);
            r_sb1[0].fe_zero  <= (r_f6 <= 0);
            r_sb1[0].fe_one   <= (r_f6 >= r_e6);
            r_sb1[0].ca_zero  <= (r_nc6 <= 0);
            r_sb1[0].ca_one   <= (r_nc6 >= NUM_W'(r_a6));
            r_sb1[0].bca_zero <= (r_bc6 <= 0);
            r_sb1[0].bca_one  <= (r_bc6 >= NUM_W'(r_a6));
            r_sb1[0].b        <= r_b6;
            r_sb1[0].f        <= r_f6;
            r_sb1[0].e        <= r_e6;
            r_dn[0] <= DIV_W'(r_sn6);
            r_dd[0] <= DIV_W'(r_den6);
            r_dn[1] <= DIV_W'(r_f6);
            r_dd[1] <= DIV_W'(r_e6);
            r_dn[2] <= DIV_W'(r_nc6);
            r_dd[2] <= DIV_W'(r_a6);
            r_dn[3] <= DIV_W'(r_bc6);
            r_dd[3] <= DIV_W'(r_a6);
            for (int k = 1; k <= Q_W; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_div1
        scm_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_dn[j]),
            .i_den  (r_dd[j]),
            .o_quot (q1[j])
        );
    end

    assign sb1_out = r_sb1[Q_W];

    always_comb begin
        s_gen = sb1_out.par ? '0 : clamp_q(sb1_out.sg_zero, sb1_out.sg_one, q1[0]);
        if (sb1_out.deg_a && sb1_out.deg_e) begin
            code8 = CASE_BOTH;
        end else if (sb1_out.deg_a) begin
            code8 = CASE_FIRST;
        end else if (sb1_out.deg_e) begin
            code8 = CASE_SECOND;
        end else if (sb1_out.par) begin
            code8 = CASE_PARALLEL;
        end else begin
            code8 = CASE_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g8    <= sb1_out.g;
            r_code8 <= code8;
            r_s8    <= s_gen;
            r_tfe8  <= clamp_q(sb1_out.fe_zero, sb1_out.fe_one, q1[1]);
            r_sca8  <= clamp_q(sb1_out.ca_zero, sb1_out.ca_one, q1[2]);
            r_sbca8 <= clamp_q(sb1_out.bca_zero, sb1_out.bca_one, q1[3]);
            r_bs8   <= $signed(sb1_out.b) * $signed({1'b0, s_gen});
            r_f8    <= $signed(sb1_out.f);
            r_e8    <= $signed(sb1_out.e);
        end
    end

    // t numerator b*s + f and its upper limit e, both scaled by 2^16
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g9    <= r_g8;
            r_code9 <= r_code8;
            r_s9    <= r_s8;
            r_tfe9  <= r_tfe8;
            r_sca9  <= r_sca8;
            r_sbca9 <= r_sbca8;
            r_tn9   <= TN_W'(r_bs8) + (TN_W'(r_f8) <<< Q_W);
            r_lim9  <= TN_W'(r_e8) <<< Q_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0].g     <= r_g9;
            r_sb2[0].code  <= r_code9;
            r_sb2[0].tneg  <= (r_tn9 < 0);
            r_sb2[0].tover <= (r_tn9 > r_lim9);
            r_sb2[0].teq   <= (r_tn9 == r_lim9);
            r_sb2[0].s_gen <= r_s9;
            r_sb2[0].s_ca  <= r_sca9;
            r_sb2[0].s_bca <= r_sbca9;
            r_sb2[0].t_fe  <= r_tfe9;
            r_tnum <= DIV_W'(r_tn9);
            r_tden <= DIV_W'(r_lim9);
            for (int k = 1; k <= Q_W; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    scm_div u_div_t (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_tnum),
        .i_den  (r_tden),
        .o_quot (qt)
    );

    assign sb2_out = r_sb2[Q_W];

    // final s and t per case
    always_comb begin
        case (sb2_out.code)
            CASE_FIRST: begin
                fin_s = '0;
                fin_t = sb2_out.t_fe;
            end
            CASE_SECOND: begin
                fin_s = sb2_out.s_ca;
                fin_t = '0;
            end
            CASE_PARALLEL, CASE_GENERAL: begin
                if (sb2_out.tneg) begin
                    fin_s = sb2_out.s_ca;
                    fin_t = '0;
                end else if (sb2_out.tover) begin
                    fin_s = sb2_out.s_bca;
                    fin_t = S_ONE;
                end else begin
                    fin_s = sb2_out.s_gen;
                    fin_t = sb2_out.teq ? S_ONE : {1'b0, qt};
                end
            end
            default: begin
                fin_s = '0;
                fin_t = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g11    <= sb2_out.g;
            r_code11 <= sb2_out.code;
            r_s11    <= fin_s;
            r_t11    <= fin_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g12    <= r_g11;
            r_code12 <= r_code11;
            for (int i = 0; i < 3; i++) begin
                r_ds[i] <= $signed(r_g11.d1[i]) * $signed({1'b0, r_s11});
                r_dt[i] <= $signed(r_g11.d2[i]) * $signed({1'b0, r_t11});
            end
        end
    end

    // c1 + c2 in Q12.24, halved and brought back to Q8.8
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_v[i] = (SUM_W'($signed(r_g12.p1[i])) <<< Q_W)
                     + (SUM_W'($signed(r_g12.p2[i])) <<< Q_W)
                     + SUM_W'(r_ds[i]) + SUM_W'(r_dt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code <= r_code12;
            for (int i = 0; i < 3; i++) begin
                if (r_code12 == CASE_BOTH) begin
                    r_mid[i] <= $signed(r_g12.p1[i]);
                end else begin
                    r_mid[i] <= $signed(sum_v[i][MID_SHIFT +: COORD_W]);
                end
            end
        end
    end

    assign o_mid_x     = r_mid[0];
    assign o_mid_y     = r_mid[1];
    assign o_mid_z     = r_mid[2];
    assign o_case_code = r_code;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word did not enter the pipe");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipe moved while frozen");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_LAT-3] |-> (r_s11 <= S_ONE && r_t11 <= S_ONE))
        else $error("s or t outside unit range");

    a_parallel_s_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S8_IDX] && r_code8 == CASE_PARALLEL) |-> (r_s8 == '0))
        else $error("parallel pair with nonzero s");

endmodule

// ===== rtl/scm_div.sv =====
// ----------------------------------------------------------------------------
// scm_div: pipelined fractional divider
// Restoring division, one quotient bit per stage, floor(num * 2^Q_W / den)
// for 0 <= num < den. Accepts one word per cycle while i_en is high.
// ----------------------------------------------------------------------------
module scm_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [scm_pkg::DIV_W-1:0] i_num,
    input  logic [scm_pkg::DIV_W-1:0] i_den,
    output logic [scm_pkg::Q_W-1:0]   o_quot
);
    import scm_pkg::*;

    logic [DIV_W-1:0] r_rem  [Q_W];
    logic [DIV_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [DIV_W-1:0] sh;
        logic [DIV_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quot;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_quot[k-1];
        end

        assign sh = {rem_in[DIV_W-2:0], 1'b0};

        always_comb begin
            if (sh >= den_in) begin
                n_rem  = sh - den_in;
                n_quot = {q_in[Q_W-2:0], 1'b1};
            end else begin
                n_rem  = sh;
                n_quot = {q_in[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_quot[k] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];

endmodule
